### hw/rtl/tfm_pkg.sv
// Package for the TDM frame level meter: fixed field widths, register
// indexes, channel codes, controller state type and the command/status structs.
// No dependencies.
package tfm_pkg;

    // Fixed field widths
    localparam int SMP_W      = 16;
    localparam int SLOT_W     = 2;
    localparam int TDM_SLOTS  = 4;
    localparam int FS_W       = 11;
    localparam int CH_W       = 2;
    localparam int MIC_CLIP_W = 12;
    localparam int REF_CLIP_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_CH     = 3;

    // Sqrt unit: 32-bit operand, 16-bit root, one root bit per cycle
    localparam int SQRT_IN_W  = 32;
    localparam int SQRT_OUT_W = 16;

    // Clip threshold on sample magnitude
    localparam logic [SMP_W-1:0] CLIP_LEVEL = 16'd32700;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MIC_A_SLOT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIC_B_SLOT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_SLOT      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_SAMPLES = 2'd3;

    // Register reset values
    localparam logic [SLOT_W-1:0] MIC_A_SLOT_RST    = 2'd0;
    localparam logic [SLOT_W-1:0] MIC_B_SLOT_RST    = 2'd2;
    localparam logic [SLOT_W-1:0] REF_SLOT_RST      = 2'd1;
    localparam logic [FS_W-1:0]   FRAME_SAMPLES_RST = 11'd512;
    localparam logic [FS_W-1:0]   FRAME_MIN         = 11'd2;

    // Channel codes
    localparam logic [CH_W-1:0] CH_MIC_A = 2'd0;
    localparam logic [CH_W-1:0] CH_MIC_B = 2'd1;
    localparam logic [CH_W-1:0] CH_REF   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DC_GO,
        ST_DC_WAIT,
        ST_MS_GO,
        ST_MS_WAIT,
        ST_SQ_WAIT,
        ST_EMIT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic            capture;
        logic            accum;
        logic            div_start;
        logic            div_ms;
        logic            dc_take;
        logic            sqrt_start;
        logic            load_out;
        logic            clear;
        logic [CH_W-1:0] ch;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic frame_end;
        logic div_done;
        logic sqrt_done;
    } t_sts;

endpackage

### hw/rtl/tfm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses no package.
module tfm_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot,
    output logic             o_done
);

    localparam int STEP_W = $clog2(DVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_q;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              q_bit;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb begin
        rem_sh  = {r_rem, r_q[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
    end

    // Control: busy for DVD_W steps, done pulses in the cycle after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

### hw/rtl/tfm_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on tfm_pkg for operand and root widths.
module tfm_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tfm_pkg::SQRT_IN_W-1:0]    i_opd,
    output logic [tfm_pkg::SQRT_OUT_W-1:0]   o_root,
    output logic                             o_done
);

    localparam int RT_W   = tfm_pkg::SQRT_OUT_W;
    localparam int IN_W   = tfm_pkg::SQRT_IN_W;
    localparam int REM_W  = RT_W + 3;
    localparam int STEP_W = $clog2(RT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RT_W - 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [IN_W-1:0]   r_opd;
    logic [REM_W-1:0]  r_rem;
    logic [RT_W-1:0]   r_root;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              r_bit;

    // Bring down two operand bits, try (4*root + 1)
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_opd[IN_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        r_bit  = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_opd  <= i_opd;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_opd  <= {r_opd[IN_W-3:0], 2'b00};
            r_rem  <= r_bit ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[RT_W-2:0], r_bit};
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

### hw/rtl/tfm_dp.sv
// Datapath: config registers, slot capture, per-channel accumulators,
// shared divider and sqrt unit, result word registers. Depends on tfm_pkg,
// tfm_div and tfm_sqrt.
module tfm_dp #(
    parameter int FRAME_MAX = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [tfm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input word
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot0,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot1,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot2,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot3,
    // control
    input  tfm_pkg::t_cmd                         i_cmd,
    output tfm_pkg::t_sts                         o_sts,
    // result word
    output logic [tfm_pkg::CH_W-1:0]              o_channel,
    output logic [tfm_pkg::SMP_W-1:0]             o_peak,
    output logic signed [tfm_pkg::SMP_W-1:0]      o_dc,
    output logic [tfm_pkg::SMP_W-1:0]             o_rms,
    output logic [tfm_pkg::MIC_CLIP_W-1:0]        o_mic_clip_cnt,
    output logic [tfm_pkg::REF_CLIP_W-1:0]        o_ref_clipped,
    output logic                                  o_last
);

    localparam int SMP_W = tfm_pkg::SMP_W;
    localparam int CNT_W = $clog2(FRAME_MAX + 1);
    localparam int SUM_W = SMP_W + CNT_W;
    localparam int SQ_W  = 2 * SMP_W - 2 + CNT_W;
    localparam int NCH   = tfm_pkg::NUM_CH;

    // Slot mux; a 2-bit index always names a present slot
    function automatic logic signed [SMP_W-1:0] slot_mux(
        input logic [tfm_pkg::SLOT_W-1:0] idx,
        input logic signed [SMP_W-1:0]    s0,
        input logic signed [SMP_W-1:0]    s1,
        input logic signed [SMP_W-1:0]    s2,
        input logic signed [SMP_W-1:0]    s3
    );
        logic signed [SMP_W-1:0] v;
        case (idx)
            2'd0:    v = s0;
            2'd1:    v = s1;
            2'd2:    v = s2;
            2'd3:    v = s3;
            default: v = s0;
        endcase
        return v;
    endfunction

    // Configuration registers
    logic [tfm_pkg::SLOT_W-1:0] r_mic_a_slot;
    logic [tfm_pkg::SLOT_W-1:0] r_mic_b_slot;
    logic [tfm_pkg::SLOT_W-1:0] r_ref_slot;
    logic [tfm_pkg::FS_W-1:0]   r_frame_samples;

    // Captured samples and accumulators
    logic signed [SMP_W-1:0]         r_smp    [NCH];
    logic [CNT_W-1:0]                r_cnt;
    logic signed [SUM_W-1:0]         r_sum    [NCH];
    logic [SQ_W-1:0]                 r_sq     [NCH];
    logic [SMP_W-1:0]                r_peak   [NCH];
    logic [tfm_pkg::MIC_CLIP_W-1:0]  r_mic_clip;
    logic [tfm_pkg::REF_CLIP_W-1:0]  r_ref_clip;
    logic [SMP_W-1:0]                r_dc;

    // Result word registers
    logic [tfm_pkg::CH_W-1:0]        r_o_channel;
    logic [SMP_W-1:0]                r_o_peak;
    logic [SMP_W-1:0]                r_o_dc;
    logic [SMP_W-1:0]                r_o_rms;
    logic [tfm_pkg::MIC_CLIP_W-1:0]  r_o_mic_clip;
    logic [tfm_pkg::REF_CLIP_W-1:0]  r_o_ref_clip;
    logic                            r_o_last;

    logic [SMP_W-1:0]                mag      [NCH];
    logic [2*SMP_W-1:0]              sq       [NCH];
    logic                            clip     [NCH];
    logic [1:0]                      mic_inc;
    logic [CNT_W-1:0]                cnt_nxt;
    logic [CNT_W-1:0]                frame_len;
    logic [31:0]                     fs_ext;

    logic signed [SUM_W-1:0]         sum_sel;
    logic [SUM_W-1:0]                sum_abs;
    logic [SQ_W-1:0]                 dividend;
    logic [SQ_W-1:0]                 quot;
    logic                            div_done;
    logic [tfm_pkg::SQRT_OUT_W-1:0]  root;
    logic                            sqrt_done;

    // Configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mic_a_slot    <= tfm_pkg::MIC_A_SLOT_RST;
            r_mic_b_slot    <= tfm_pkg::MIC_B_SLOT_RST;
            r_ref_slot      <= tfm_pkg::REF_SLOT_RST;
            r_frame_samples <= tfm_pkg::FRAME_SAMPLES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tfm_pkg::REG_MIC_A_SLOT:    r_mic_a_slot    <= i_cfg_data[tfm_pkg::SLOT_W-1:0];
                tfm_pkg::REG_MIC_B_SLOT:    r_mic_b_slot    <= i_cfg_data[tfm_pkg::SLOT_W-1:0];
                tfm_pkg::REG_REF_SLOT:      r_ref_slot      <= i_cfg_data[tfm_pkg::SLOT_W-1:0];
                tfm_pkg::REG_FRAME_SAMPLES: r_frame_samples <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the three selected slots of the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_smp[0] <= slot_mux(r_mic_a_slot, i_slot0, i_slot1, i_slot2, i_slot3);
            r_smp[1] <= slot_mux(r_mic_b_slot, i_slot0, i_slot1, i_slot2, i_slot3);
            r_smp[2] <= slot_mux(r_ref_slot,   i_slot0, i_slot1, i_slot2, i_slot3);
        end
    end

    // Magnitude, square and clip flag per channel
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            mag[c]  = r_smp[c][SMP_W-1] ? (SMP_W'(0) - r_smp[c]) : r_smp[c];
            sq[c]   = {{SMP_W{1'b0}}, mag[c]} * {{SMP_W{1'b0}}, mag[c]};
            clip[c] = (mag[c] >= tfm_pkg::CLIP_LEVEL);
        end
        mic_inc = {1'b0, clip[0]} + {1'b0, clip[1]};
    end

    // Effective frame length, clamped to [2, FRAME_MAX]
    always_comb begin
        fs_ext  = 32'(r_frame_samples);
        cnt_nxt = r_cnt + 1'b1;
        if (r_frame_samples < tfm_pkg::FRAME_MIN) begin
            frame_len = CNT_W'(2);
        end else if (fs_ext > 32'(FRAME_MAX)) begin
            frame_len = CNT_W'(FRAME_MAX);
        end else begin
            frame_len = CNT_W'(r_frame_samples);
        end
    end

    // Accumulators: update per word, clear when the last result of a frame is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt      <= '0;
            r_mic_clip <= '0;
            r_ref_clip <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c]  <= '0;
                r_sq[c]   <= '0;
                r_peak[c] <= '0;
            end
        end else if (i_cmd.accum) begin
            r_cnt      <= cnt_nxt;
            r_mic_clip <= r_mic_clip + tfm_pkg::MIC_CLIP_W'(mic_inc);
            r_ref_clip <= r_ref_clip + tfm_pkg::REF_CLIP_W'(clip[2]);
            for (int c = 0; c < NCH; c++) begin
                r_sum[c] <= r_sum[c] + {{(SUM_W-SMP_W){r_smp[c][SMP_W-1]}}, r_smp[c]};
                r_sq[c]  <= r_sq[c] + SQ_W'(sq[c]);
                if (mag[c] > r_peak[c]) begin
                    r_peak[c] <= mag[c];
                end
            end
        end
    end

    // Divider operand: |sum| for the DC value, square sum for the mean square
    always_comb begin
        sum_sel  = r_sum[i_cmd.ch];
        sum_abs  = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
        dividend = i_cmd.div_ms ? r_sq[i_cmd.ch] : {{(SQ_W-SUM_W){1'b0}}, sum_abs};
    end

    tfm_div #(
        .DVD_W (SQ_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_cnt),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    tfm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_opd   (quot[tfm_pkg::SQRT_IN_W-1:0]),
        .o_root  (root),
        .o_done  (sqrt_done)
    );

    // DC: restore the sign of the sum on the truncated quotient
    always_ff @(posedge i_clk) begin
        if (i_cmd.dc_take) begin
            r_dc <= sum_sel[SUM_W-1] ? (SMP_W'(0) - quot[SMP_W-1:0]) : quot[SMP_W-1:0];
        end
    end

    // Result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_channel  <= i_cmd.ch;
            r_o_peak     <= r_peak[i_cmd.ch];
            r_o_dc       <= r_dc;
            r_o_rms      <= root;
            r_o_mic_clip <= r_mic_clip;
            r_o_ref_clip <= r_ref_clip;
            r_o_last     <= (i_cmd.ch == tfm_pkg::CH_REF);
        end
    end

    assign o_sts.frame_end = (cnt_nxt >= frame_len);
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;

    assign o_channel      = r_o_channel;
    assign o_peak         = r_o_peak;
    assign o_dc           = r_o_dc;
    assign o_rms          = r_o_rms;
    assign o_mic_clip_cnt = r_o_mic_clip;
    assign o_ref_clipped  = r_o_ref_clip;
    assign o_last         = r_o_last;

endmodule

### hw/rtl/tfm_ctrl.sv
// Controller: sequences capture, accumulate, and the per-channel
// divide / divide / sqrt / emit steps at frame end. Depends on tfm_pkg.
module tfm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  tfm_pkg::t_sts i_sts,
    output tfm_pkg::t_cmd o_cmd
);

    tfm_pkg::t_state             r_state;
    tfm_pkg::t_state             n_state;
    logic [tfm_pkg::CH_W-1:0]    r_ch;
    logic [tfm_pkg::CH_W-1:0]    n_ch;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfm_pkg::ST_IDLE;
            r_ch        <= tfm_pkg::CH_MIC_A;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ch       = r_ch;
        o_cmd      = '0;
        o_cmd.ch   = r_ch;
        o_in_stall = 1'b1;
        // output register is free when empty or being taken this cycle
        out_free    = !r_out_valid || !i_out_stall;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            tfm_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = tfm_pkg::ST_ACC;
                end
            end
            tfm_pkg::ST_ACC: begin
                o_cmd.accum = 1'b1;
                if (i_sts.frame_end) begin
                    n_ch    = tfm_pkg::CH_MIC_A;
                    n_state = tfm_pkg::ST_DC_GO;
                end else begin
                    n_state = tfm_pkg::ST_IDLE;
                end
            end
            tfm_pkg::ST_DC_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = tfm_pkg::ST_DC_WAIT;
            end
            tfm_pkg::ST_DC_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.dc_take = 1'b1;
                    n_state       = tfm_pkg::ST_MS_GO;
                end
            end
            tfm_pkg::ST_MS_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_ms    = 1'b1;
                n_state         = tfm_pkg::ST_MS_WAIT;
            end
            tfm_pkg::ST_MS_WAIT: begin
                o_cmd.div_ms = 1'b1;
                if (i_sts.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state          = tfm_pkg::ST_SQ_WAIT;
                end
            end
            tfm_pkg::ST_SQ_WAIT: begin
                if (i_sts.sqrt_done) begin
                    n_state = tfm_pkg::ST_EMIT;
                end
            end
            tfm_pkg::ST_EMIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    if (r_ch == tfm_pkg::CH_REF) begin
                        o_cmd.clear = 1'b1;
                        n_state     = tfm_pkg::ST_IDLE;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = tfm_pkg::ST_DC_GO;
                    end
                end
            end
            default: begin
                n_state = tfm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hw/rtl/tdm_frame_level_meter_core.sv
// TDM frame level meter, top level: controller plus datapath.
// Depends on tfm_pkg, tfm_ctrl and tfm_dp.
//
// Input channel: one word per TDM sample period (i_slot0..i_slot3), taken
// when i_in_valid is high and o_in_stall is low. Three configured slots
// (two mics, one reference) are accumulated per word: sum, sum of squares,
// peak magnitude and clip counts.
// A word that does not close a frame goes through capture, then accumulate.
// The word that closes a frame runs, per channel, a bit-serial divide for
// DC, a second for the mean square (W quotient bits each, W = sum-of-squares
// width, 41 at FRAME_MAX = 1024) and a bit-serial square root with a 16-bit
// root, then emits that channel's result word.
// Output channel: three result words per frame (channel 0, 1, 2; o_last on
// the third) from an output register, taken when o_out_valid is high and
// i_out_stall is low. A stall holds the word; the next channel's result
// waits in the sequencer until the register frees. Once the third word is
// loaded the accumulators clear and a new input word is taken, even while
// that result word still waits.
// Configuration: i_cfg_valid/o_cfg_ready, always ready; write only when idle.
// Reset (i_rst_n low, synchronous) restores the register defaults and clears
// all accumulators and the output register's valid.
module tdm_frame_level_meter_core #(
    parameter int FRAME_MAX = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tfm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [tfm_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input words
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot0,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot1,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot2,
    input  logic signed [tfm_pkg::SMP_W-1:0]      i_slot3,
    // result words
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [tfm_pkg::CH_W-1:0]              o_channel,
    output logic [tfm_pkg::SMP_W-1:0]             o_peak,
    output logic signed [tfm_pkg::SMP_W-1:0]      o_dc,
    output logic [tfm_pkg::SMP_W-1:0]             o_rms,
    output logic [tfm_pkg::MIC_CLIP_W-1:0]        o_mic_clip_cnt,
    output logic [tfm_pkg::REF_CLIP_W-1:0]        o_ref_clipped,
    output logic                                  o_last
);

    tfm_pkg::t_cmd cmd;
    tfm_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    tfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tfm_dp #(
        .FRAME_MAX (FRAME_MAX)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_slot0        (i_slot0),
        .i_slot1        (i_slot1),
        .i_slot2        (i_slot2),
        .i_slot3        (i_slot3),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_channel      (o_channel),
        .o_peak         (o_peak),
        .o_dc           (o_dc),
        .o_rms          (o_rms),
        .o_mic_clip_cnt (o_mic_clip_cnt),
        .o_ref_clipped  (o_ref_clipped),
        .o_last         (o_last)
    );

    // Capture happens on exactly the accepted input words
    a_capture_is_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture == (i_in_valid && !o_in_stall))
        else $error("capture does not match input accept");

    // A held result word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_out_valid && i_out_stall))
        else $error("result register loaded while stalled");

    // The frame-closing word is the reference channel, and only it
    a_last_is_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_channel == tfm_pkg::CH_REF)))
        else $error("last flag does not match reference channel");

    // Accumulators clear only together with loading the last result
    a_clear_with_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |-> (cmd.load_out && cmd.ch == tfm_pkg::CH_REF))
        else $error("accumulators cleared outside frame end");

endmodule
